/* rtl/sst_pkg.sv */
// shared types and constants for the sleep timeout table
// no dependencies; imported by every module of the block
`default_nettype none

package sst_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int NUM_GROUPS = 16;

  localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int GPAD     = (NUM_GROUPS > 16) ? NUM_GROUPS : 16;
  localparam int GIDX_W   = $clog2(GPAD);
  localparam int GROUP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [2:0] {
    CMD_OPEN    = 3'd0,
    CMD_SLEEP   = 3'd1,
    CMD_WAKEUP  = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_CONNECT = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_CMD  = 3'd2,
    ST_AS_IS    = 3'd3,
    ST_NOT_OPEN = 3'd4
  } status_e;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  group;
    logic [31:0] tag;
    logic [15:0] ticks;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  out_group;
    logic [31:0] out_tag;
    logic [3:0]  out_slot;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // command token walking down the row of slot cells
  typedef struct packed {
    logic        active;
    cmd_e        cmd;
    logic [3:0]  grp;
    logic [31:0] tag;
    logic [15:0] ticks;
    logic        claimed;
    logic [3:0]  slot;
  } tok_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  grp;
    logic [31:0] tag;
    logic [3:0]  slot;
  } wake_t;

endpackage

`default_nettype wire

/* rtl/sst_cell.sv */
// one slot of the timeout table: busy flag, group, tag and tick count
// depends on sst_pkg; acts on the command token passing through it
`default_nettype none

module sst_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic [sst_pkg::SLOT_W-1:0] idx,
  input  wire sst_pkg::tok_t         tok_in,
  output sst_pkg::tok_t              tok_out,
  output sst_pkg::wake_t             wake
);
  import sst_pkg::*;

  logic        busy;
  logic [3:0]  grp;
  logic [31:0] tag;
  logic [15:0] count;

  logic  grp_hit;
  logic  rel;
  logic  claim;
  logic  dec;
  tok_t  tok_next;

  always_comb begin
    grp_hit = (grp == tok_in.grp);
    rel = tok_in.active && busy &&
          (((tok_in.cmd == CMD_WAKEUP) && grp_hit && (tag == tok_in.tag)) ||
           ((tok_in.cmd == CMD_CLOSE) && grp_hit) ||
           ((tok_in.cmd == CMD_TICK) && (count <= 16'd1)));
    claim = tok_in.active && (tok_in.cmd == CMD_SLEEP) && !busy && !tok_in.claimed;
    dec = tok_in.active && busy && (tok_in.cmd == CMD_TICK) && !rel;

    tok_next = tok_in;
    if (claim) begin
      tok_next.claimed = 1'b1;
      tok_next.slot    = 4'(idx);
    end

    wake = '0;
    if (rel) begin
      wake.valid = 1'b1;
      wake.grp   = grp;
      wake.tag   = tag;
      wake.slot  = 4'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      tok_out.active <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
      if (claim) begin
        busy <= 1'b1;
      end else if (rel) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && claim) begin
      grp   <= tok_in.grp;
      tag   <= tok_in.tag;
      count <= tok_in.ticks;
    end else if (adv && dec) begin
      count <= count - 16'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/sleep_timeout_table_core.sv */
// sleep timeout table: top level with group table, command token and result register
// depends on sst_pkg and sst_cell (one cell per slot)
// open, connect, bad commands and unopened groups complete in the next cycle
// sleep, wakeup, close and tick walk the slot row, stalled while res_ready low holds
// the result register; no new request is taken before the token leaves the row
// reset (rst, synchronous) frees all slots and closes all groups
`default_nettype none

module sleep_timeout_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire sst_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output sst_pkg::res_t      res
);
  import sst_pkg::*;

  logic [NUM_GROUPS-1:0] group_open;
  logic                  busy;
  tok_t                  tok [NUM_SLOTS+1];
  wake_t                 wk  [NUM_SLOTS];
  wake_t                 wake_any;
  logic [NUM_SLOTS:0]    act;

  logic              adv;
  logic              req_fire;
  logic [GPAD-1:0]   open_pad;
  logic [GIDX_W-1:0] grp_idx;
  logic              open_ok;
  logic              free_found;
  logic [GROUP_W-1:0] free_idx;
  logic              is_chain;
  res_t              imm_res;
  res_t              end_res;
  tok_t              last_tok;

  assign adv       = !res_valid || res_ready;
  assign req_ready = !busy && adv;
  assign req_fire  = req_valid && req_ready;
  assign last_tok  = tok[NUM_SLOTS];

  // row of slot cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    sst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .idx     (SLOT_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .wake    (wk[i])
    );
  end

  always_comb begin
    wake_any = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      wake_any = wake_t'(wake_any | wk[i]);
    end
    for (int i = 0; i <= NUM_SLOTS; i++) begin
      act[i] = tok[i].active;
    end
  end

  // lowest free group and open check
  always_comb begin
    open_pad   = GPAD'(group_open);
    grp_idx    = GIDX_W'(req.group);
    open_ok    = open_pad[grp_idx];
    free_found = 1'b0;
    free_idx   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (!group_open[g]) begin
        free_found = 1'b1;
        free_idx   = GROUP_W'(g);
      end
    end
  end

  // requests that complete at once
  always_comb begin
    is_chain = 1'b0;
    imm_res  = '0;
    imm_res.kind = KIND_DONE;
    imm_res.last = 1'b1;
    case (req.command)
      CMD_OPEN: begin
        if (free_found) begin
          imm_res.out_group = 4'(free_idx);
          imm_res.status    = ST_OK;
        end else begin
          imm_res.status    = ST_FULL;
        end
      end
      CMD_SLEEP, CMD_WAKEUP, CMD_CLOSE: begin
        if (open_ok) begin
          is_chain = 1'b1;
        end else begin
          imm_res.out_group = req.group;
          imm_res.status    = ST_NOT_OPEN;
        end
      end
      CMD_CONNECT: imm_res.status = ST_AS_IS;
      CMD_TICK:    is_chain = 1'b1;
      default:     imm_res.status = ST_BAD_CMD;
    endcase
  end

  // completion when the token leaves the last cell
  always_comb begin
    end_res      = '0;
    end_res.kind = KIND_DONE;
    end_res.last = 1'b1;
    end_res.status = ST_OK;
    if (last_tok.cmd != CMD_TICK) begin
      end_res.out_group = last_tok.grp;
    end
    if (last_tok.cmd == CMD_SLEEP) begin
      if (last_tok.claimed) begin
        end_res.out_slot = last_tok.slot;
      end else begin
        end_res.status = ST_FULL;
      end
    end
  end

  // token entry and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      tok[0].active <= 1'b0;
    end else begin
      if (req_fire && is_chain) begin
        busy           <= 1'b1;
        tok[0].active  <= 1'b1;
        tok[0].cmd     <= cmd_e'(req.command);
        tok[0].grp     <= req.group;
        tok[0].tag     <= req.tag;
        tok[0].ticks   <= req.ticks;
        tok[0].claimed <= 1'b0;
        tok[0].slot    <= '0;
      end else if (adv) begin
        tok[0].active <= 1'b0;
        if (last_tok.active) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // group table
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= '0;
    end else if (req_fire && (req.command == CMD_OPEN) && free_found) begin
      group_open[free_idx] <= 1'b1;
    end else if (adv && last_tok.active && (last_tok.cmd == CMD_CLOSE)) begin
      group_open <= NUM_GROUPS'(open_pad & ~(GPAD'(1) << GIDX_W'(last_tok.grp)));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= (req_fire && !is_chain) || wake_any.valid || last_tok.active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req_fire && !is_chain) begin
        res <= imm_res;
      end else if (wake_any.valid) begin
        res.kind      <= KIND_WAKE;
        res.out_group <= wake_any.grp;
        res.out_tag   <= wake_any.tag;
        res.out_slot  <= wake_any.slot;
        res.status    <= ST_OK;
        res.last      <= 1'b0;
      end else if (last_tok.active) begin
        res <= end_res;
      end
    end
  end

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(act))
    else $error("more than one command token in the slot row");

  a_busy_token: assert property (@(posedge clk) disable iff (rst) busy |-> $onehot(act))
    else $error("busy without a command token");

  a_idle_token: assert property (@(posedge clk) disable iff (rst) !busy |-> (act == '0))
    else $error("command token present while idle");

  a_req_effect: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (res_valid || busy))
    else $error("request accepted with no effect");

  a_wake_busy: assert property (@(posedge clk) disable iff (rst)
    wake_any.valid |-> busy)
    else $error("wake raised while idle");

endmodule

`default_nettype wire
